// ===== rtl/set_assoc_cache_controller_macros.svh =====
// assertion macros shared by the cache directory rtl
`ifndef SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cache directory check failed");

// next-cycle implication
`define SCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cache directory sequencing check failed");

`endif

// ===== rtl/scc_pkg.sv =====
// shared types and constants of the cache directory
`default_nettype none

package scc_pkg;

	localparam int ADDR_W        = 64;
	localparam int BYTES_W       = 9;
	localparam int TIME_W        = 19;
	localparam int DLY_W         = 16;
	localparam int MAX_LINE_BITS = 8;
	localparam int IN_TDATA_W    = 80;
	localparam int OUT_TDATA_W   = 96;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_BITS   = 3'd0,
		REG_INDEX_BITS    = 3'd1,
		REG_WAYS_USED     = 3'd2,
		REG_WRITE_THROUGH = 3'd3,
		REG_ALLOC_ON_WR   = 3'd4,
		REG_BUS_DELAY     = 3'd5,
		REG_HIT_DELAY     = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_RESP = 2'd0,
		KIND_RD   = 2'd1,
		KIND_WR   = 2'd2
	} item_kind_t;

	typedef struct packed {
		logic [3:0]       offset_bits;
		logic [3:0]       index_bits;
		logic [3:0]       ways_used;
		logic             write_through_mode;
		logic             allocate_on_write;
		logic [DLY_W-1:0] bus_delay;
		logic [DLY_W-1:0] hit_delay;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		offset_bits:        4'd6,
		index_bits:         4'd6,
		ways_used:          4'd8,
		write_through_mode: 1'b0,
		allocate_on_write:  1'b1,
		bus_delay:          16'd0,
		hit_delay:          16'd1
	};

endpackage

`default_nettype wire

// ===== rtl/scc_dir_ram.sv =====
// directory memory, one set per row, with clearing sweep after reset
`default_nettype none

module scc_dir_ram #(
	parameter int DEPTH = 1024,
	parameter int ROW_W = 656,
	localparam int RA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [RA_W-1:0]  rd_addr,
	output logic [ROW_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [RA_W-1:0]  wr_addr,
	input  logic [ROW_W-1:0] wr_data,
	output logic             busy
);

	localparam int CLR_W = RA_W + 1;
	localparam logic [CLR_W-1:0] CLR_END = CLR_W'(DEPTH);

	logic [ROW_W-1:0] mem_q [DEPTH];
	logic [ROW_W-1:0] rd_data_q;
	logic [CLR_W-1:0] clr_q;

	assign busy    = (clr_q != CLR_END);
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + CLR_W'(1);
		end
	end

	// zero rows clear valid and dirty of every way
	always_ff @(posedge clk) begin
		if (busy) begin
			mem_q[clr_q[RA_W-1:0]] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scc_way_scan.sv =====
// tag match and age update across the ways of one set
`default_nettype none

module scc_way_scan #(
	parameter int WAYS = 8,
	parameter int AGE_BITS = 16,
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic [WAYS-1:0]                       way_en,
	input  logic [WAYS-1:0]                       valid,
	input  logic [WAYS-1:0][scc_pkg::ADDR_W-1:0]  tags,
	input  logic [WAYS-1:0][AGE_BITS-1:0]         ages_in,
	input  logic [scc_pkg::ADDR_W-1:0]            tag,
	output logic [WAYS-1:0][AGE_BITS-1:0]         ages_out,
	output logic                                  hit,
	output logic [WAY_W-1:0]                      hit_way
);

	import scc_pkg::*;

	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	always_comb begin
		ages_out = ages_in;
		hit      = 1'b0;
		hit_way  = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (way_en[w] && valid[w]) begin
				if (tags[w] == tag) begin
					// last matching way wins
					hit         = 1'b1;
					hit_way     = WAY_W'(w);
					ages_out[w] = '0;
				end else if (ages_in[w] != AGE_MAX) begin
					ages_out[w] = ages_in[w] + AGE_BITS'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scc_victim.sv =====
// victim choice: first invalid way, else the oldest, lowest way on ties
`default_nettype none

module scc_victim #(
	parameter int WAYS = 8,
	parameter int AGE_BITS = 16,
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic [WAYS-1:0]               way_en,
	input  logic [WAYS-1:0]               valid,
	input  logic [WAYS-1:0][AGE_BITS-1:0] ages,
	output logic [WAY_W-1:0]              victim,
	output logic                          full
);

	logic                found;
	logic [AGE_BITS-1:0] best;

	always_comb begin
		victim = '0;
		found  = 1'b0;
		best   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (way_en[w] && !found) begin
				if (!valid[w]) begin
					victim = WAY_W'(w);
					found  = 1'b1;
				end else if (w == 0 || ages[w] > best) begin
					best   = ages[w];
					victim = WAY_W'(w);
				end
			end
		end
		full = !found;
	end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_controller.sv =====
// top level of the set-associative cache directory controller
// Each access word reads its set row from the directory memory in the cycle it is
// accepted, spends state ST_MATCH on tag match and aging and ST_DECIDE on victim
// choice and the row write-back, then hands out one to three result words, one per
// cycle while the output side takes them, through an output register. The next
// access is taken the cycle after the final response is loaded, while that response
// still waits at the output. After reset the directory memory is cleared one set per
// cycle, and no access is taken during that sweep; configuration writes are taken at
// any time.
`default_nettype none

`include "set_assoc_cache_controller_macros.svh"

module set_assoc_cache_controller #(
	parameter int MAX_WAYS = 8,
	parameter int MAX_SETS = 1024,
	parameter int AGE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// access words
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// address [63:0], byte_count [72:64], zero fill
	input  logic [scc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// func [0]
	input  logic [0:0]                        s_tuser,
	// result words
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// lower_address [63:0], lower_bytes [72:64], hit_flag [73], replaced_flag [74],
	// local_time [93:75], zero fill
	output logic [scc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// item_kind [1:0]
	output logic [1:0]                        m_tuser,
	// last_item
	output logic                              m_tlast,
	// configuration
	input  logic                              cfg_we,
	input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import scc_pkg::*;

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAYN_W = $clog2(MAX_WAYS + 1);
	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int MIB    = $clog2(MAX_SETS + 1) - 1;
	localparam int VAL_LO = 0;
	localparam int DRT_LO = MAX_WAYS;
	localparam int TAG_LO = 2 * MAX_WAYS;
	localparam int AGE_LO = TAG_LO + MAX_WAYS * ADDR_W;
	localparam int ROW_W  = AGE_LO + MAX_WAYS * AGE_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t state_q;
	cfg_t   cfg_q;

	// effective configuration
	logic [3:0]        ob_eff;
	logic [3:0]        ib_eff;
	logic [4:0]        shamt;
	logic [WAYN_W-1:0] nw_eff;
	logic [MAX_WAYS-1:0] way_en;
	logic [SET_W-1:0]  set_mask;

	// input side
	logic              in_accept;
	logic [ADDR_W-1:0] in_address;
	logic [ADDR_W-1:0] in_addr_sh;
	logic [SET_W-1:0]  in_set;

	logic              func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [SET_W-1:0]  set_q;

	// directory row
	logic              ram_busy;
	logic              wr_en;
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  wr_row;
	logic [MAX_WAYS-1:0]               rd_valid, rd_dirty;
	logic [MAX_WAYS-1:0][ADDR_W-1:0]   rd_tags;
	logic [MAX_WAYS-1:0][AGE_BITS-1:0] rd_ages;
	logic [MAX_WAYS-1:0]               wr_valid, wr_dirty;
	logic [MAX_WAYS-1:0][ADDR_W-1:0]   wr_tags;
	logic [MAX_WAYS-1:0][AGE_BITS-1:0] wr_ages;

	// scan stage
	logic [ADDR_W-1:0] tag_cur;
	logic [MAX_WAYS-1:0][AGE_BITS-1:0] scan_ages;
	logic              scan_hit;
	logic [WAY_W-1:0]  scan_hit_way;
	logic [MAX_WAYS-1:0][AGE_BITS-1:0] ages_s1;
	logic              hit_s1;
	logic [WAY_W-1:0]  hit_way_s1;
	logic [ADDR_W-1:0] tag_s1;

	// decide stage
	logic [WAY_W-1:0]  vic_way;
	logic              vic_full;
	logic [ADDR_W-1:0] line_base;
	logic [BYTES_W-1:0] line_bytes;
	logic [ADDR_W-1:0] vic_addr;
	logic [TIME_W-1:0] time_base;
	logic [TIME_W-1:0] time_d;
	logic [1:0]        n_req_d;
	logic              rep_d;
	item_kind_t        req_kind_d [2];
	logic [ADDR_W-1:0] req_addr_d [2];
	logic [BYTES_W-1:0] req_bytes_d [2];

	item_kind_t        req_kind_q [2];
	logic [ADDR_W-1:0] req_addr_q [2];
	logic [BYTES_W-1:0] req_bytes_q [2];
	logic [1:0]        n_req_q;
	logic [1:0]        emit_idx_q;
	logic              resp_hit_q;
	logic              resp_rep_q;
	logic [TIME_W-1:0] resp_time_q;

	// output register
	logic              out_valid_q;
	logic              out_free;
	item_kind_t        out_kind_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [BYTES_W-1:0] out_bytes_q;
	logic              out_hit_q;
	logic              out_rep_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OFFSET_BITS:   cfg_q.offset_bits <= cfg_data[3:0];
				REG_INDEX_BITS:    cfg_q.index_bits <= cfg_data[3:0];
				REG_WAYS_USED:     cfg_q.ways_used <= cfg_data[3:0];
				REG_WRITE_THROUGH: cfg_q.write_through_mode <= cfg_data[0];
				REG_ALLOC_ON_WR:   cfg_q.allocate_on_write <= cfg_data[0];
				REG_BUS_DELAY:     cfg_q.bus_delay <= cfg_data[DLY_W-1:0];
				REG_HIT_DELAY:     cfg_q.hit_delay <= cfg_data[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(cfg_q.offset_bits) > MAX_LINE_BITS) begin
			ob_eff = 4'(MAX_LINE_BITS);
		end else begin
			ob_eff = cfg_q.offset_bits;
		end
		if (int'(cfg_q.index_bits) > MIB) begin
			ib_eff = 4'(MIB);
		end else begin
			ib_eff = cfg_q.index_bits;
		end
		if (cfg_q.ways_used == '0) begin
			nw_eff = WAYN_W'(1);
		end else if (int'(cfg_q.ways_used) > MAX_WAYS) begin
			nw_eff = WAYN_W'(MAX_WAYS);
		end else begin
			nw_eff = WAYN_W'(cfg_q.ways_used);
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			way_en[w] = (w < int'(nw_eff));
		end
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (i < int'(ib_eff));
		end
	end

	assign shamt = 5'(ob_eff) + 5'(ib_eff);

	// set index straight from the incoming word so the row read starts at once
	assign s_tready   = (state_q == ST_IDLE) && !ram_busy;
	assign in_accept  = s_tvalid && s_tready;
	assign in_address = s_tdata[ADDR_W-1:0];
	assign in_addr_sh = in_address >> ob_eff;
	assign in_set     = in_addr_sh[SET_W-1:0] & set_mask;

	scc_dir_ram #(
		.DEPTH (MAX_SETS),
		.ROW_W (ROW_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (in_set),
		.rd_data (rd_row),
		.wr_en   (wr_en),
		.wr_addr (set_q),
		.wr_data (wr_row),
		.busy    (ram_busy)
	);

	assign rd_valid = rd_row[VAL_LO +: MAX_WAYS];
	assign rd_dirty = rd_row[DRT_LO +: MAX_WAYS];
	assign rd_tags  = rd_row[TAG_LO +: MAX_WAYS * ADDR_W];
	assign rd_ages  = rd_row[AGE_LO +: MAX_WAYS * AGE_BITS];
	assign wr_row   = {wr_ages, wr_tags, wr_dirty, wr_valid};
	assign wr_en    = (state_q == ST_DECIDE);

	assign tag_cur = addr_q >> shamt;

	scc_way_scan #(
		.WAYS     (MAX_WAYS),
		.AGE_BITS (AGE_BITS)
	) u_scan (
		.way_en   (way_en),
		.valid    (rd_valid),
		.tags     (rd_tags),
		.ages_in  (rd_ages),
		.tag      (tag_cur),
		.ages_out (scan_ages),
		.hit      (scan_hit),
		.hit_way  (scan_hit_way)
	);

	scc_victim #(
		.WAYS     (MAX_WAYS),
		.AGE_BITS (AGE_BITS)
	) u_victim (
		.way_en (way_en),
		.valid  (rd_valid),
		.ages   (ages_s1),
		.victim (vic_way),
		.full   (vic_full)
	);

	// payload captured along the way
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q  <= s_tuser[0];
			addr_q  <= in_address;
			bytes_q <= s_tdata[ADDR_W +: BYTES_W];
			set_q   <= in_set;
		end
		if (state_q == ST_MATCH) begin
			ages_s1    <= scan_ages;
			hit_s1     <= scan_hit;
			hit_way_s1 <= scan_hit_way;
			tag_s1     <= tag_cur;
		end
		if (state_q == ST_DECIDE) begin
			for (int i = 0; i < 2; i++) begin
				req_kind_q[i]  <= req_kind_d[i];
				req_addr_q[i]  <= req_addr_d[i];
				req_bytes_q[i] <= req_bytes_d[i];
			end
			resp_hit_q  <= hit_s1;
			resp_rep_q  <= rep_d;
			resp_time_q <= time_d;
		end
	end

	assign line_base  = addr_q & ~((ADDR_W'(1) << ob_eff) - ADDR_W'(1));
	assign line_bytes = BYTES_W'(1) << ob_eff;
	assign vic_addr   = (rd_tags[vic_way] << shamt) | (ADDR_W'(set_q) << ob_eff);
	assign time_base  = TIME_W'(cfg_q.bus_delay) + TIME_W'(cfg_q.hit_delay);

	// row update and the list of lower requests
	always_comb begin
		wr_valid = rd_valid;
		wr_dirty = rd_dirty;
		wr_tags  = rd_tags;
		wr_ages  = ages_s1;
		n_req_d  = 2'd0;
		rep_d    = 1'b0;
		for (int i = 0; i < 2; i++) begin
			req_kind_d[i]  = KIND_WR;
			req_addr_d[i]  = addr_q;
			req_bytes_d[i] = bytes_q;
		end
		if (hit_s1) begin
			if (func_q) begin
				if (cfg_q.write_through_mode) begin
					n_req_d = 2'd1;
				end else begin
					wr_dirty[hit_way_s1] = 1'b1;
				end
			end
		end else if (func_q && !cfg_q.allocate_on_write) begin
			n_req_d = 2'd1;
		end else begin
			req_kind_d[0]  = KIND_RD;
			req_addr_d[0]  = line_base;
			req_bytes_d[0] = line_bytes;
			n_req_d        = 2'd1;
			// dirty victim goes back to its own line address
			if (vic_full && rd_dirty[vic_way]) begin
				req_addr_d[1]  = vic_addr;
				req_bytes_d[1] = line_bytes;
				n_req_d        = 2'd2;
			end
			rep_d             = vic_full;
			wr_valid[vic_way] = 1'b1;
			wr_dirty[vic_way] = func_q;
			wr_tags[vic_way]  = tag_s1;
			wr_ages[vic_way]  = '0;
		end
		time_d = time_base
			+ ((n_req_d != 2'd0) ? TIME_W'(cfg_q.bus_delay) : TIME_W'(0))
			+ ((n_req_d == 2'd2) ? TIME_W'(cfg_q.bus_delay) : TIME_W'(0));
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_req_q     <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_RESP;
			out_addr_q  <= '0;
			out_bytes_q <= '0;
			out_hit_q   <= 1'b0;
			out_rep_q   <= 1'b0;
			out_time_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// a word taken with no new one loaded behind it empties the register
			if (m_tready && !((state_q == ST_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					n_req_q    <= n_req_d;
					emit_idx_q <= '0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (emit_idx_q < n_req_q) begin
							out_kind_q  <= req_kind_q[emit_idx_q[0]];
							out_addr_q  <= req_addr_q[emit_idx_q[0]];
							out_bytes_q <= req_bytes_q[emit_idx_q[0]];
							out_hit_q   <= 1'b0;
							out_rep_q   <= 1'b0;
							out_time_q  <= '0;
							out_last_q  <= 1'b0;
							emit_idx_q  <= emit_idx_q + 2'd1;
						end else begin
							out_kind_q  <= KIND_RESP;
							out_addr_q  <= '0;
							out_bytes_q <= '0;
							out_hit_q   <= resp_hit_q;
							out_rep_q   <= resp_rep_q;
							out_time_q  <= resp_time_q;
							out_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_time_q, out_rep_q, out_hit_q, out_bytes_q, out_addr_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`SCC_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, ram_busy, !s_tready)
	`SCC_ASSERT_NXT(a_accept_to_scan, clk, arst_n, s_tvalid && s_tready, state_q == ST_MATCH)
	`SCC_ASSERT_IMP(a_resp_is_last, clk, arst_n, m_tvalid && (m_tuser == KIND_RESP), m_tlast)
	`SCC_ASSERT_IMP(a_req_not_last, clk, arst_n, m_tvalid && (m_tuser != KIND_RESP), !m_tlast)
	`SCC_ASSERT_IMP(a_victim_in_use, clk, arst_n, (state_q == ST_DECIDE) && !hit_s1, WAYN_W'(vic_way) < nw_eff)
	`SCC_ASSERT_IMP(a_emit_bound, clk, arst_n, state_q == ST_EMIT, emit_idx_q <= n_req_q)

endmodule

`default_nettype wire
